>>> rtl/sss_pkg.sv
// shared types, constants and lookup functions of the seven-segment scan driver
`timescale 1ns / 1ps

package sss_pkg;

    // field widths
    localparam int VALUE_W    = 16;
    localparam int CLAMP_W    = 14;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 3;
    localparam int PLACE_W    = 2;
    localparam int DIGIT_W    = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int PROD_W     = 30;
    localparam int TENS_W     = 11;

    typedef logic [VALUE_W-1:0]   t_value;
    typedef logic [CLAMP_W-1:0]   t_clamped;
    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [POS_W-1:0]     t_pos;
    typedef logic [PLACE_W-1:0]   t_place;
    typedef logic [DIGIT_W-1:0]   t_digit;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [PROD_W-1:0]    t_prod;

    // register indexes of the configuration port
    localparam t_cfg_idx REG_POINT_MASK = t_cfg_idx'(0);
    localparam t_cfg_idx REG_EXTRA_BYTE = t_cfg_idx'(1);

    // digit places inside one four-digit group
    localparam t_place PLACE_THOUSANDS = 2'd0;
    localparam t_place PLACE_HUNDREDS  = 2'd1;
    localparam t_place PLACE_TENS      = 2'd2;
    localparam t_place PLACE_ONES      = 2'd3;

    // largest value a four-digit group can show
    localparam t_clamped VALUE_CLAMP = t_clamped'(9999);

    // reciprocals for constant division, exact for values up to the clamp
    localparam t_prod RECIP_1000 = t_prod'(8389);
    localparam int    SHIFT_1000 = 23;
    localparam t_prod RECIP_100  = t_prod'(5243);
    localparam int    SHIFT_100  = 19;
    localparam t_prod RECIP_10   = t_prod'(52429);
    localparam int    SHIFT_10   = 19;

    // bit of the segment byte that carries the decimal point
    localparam int POINT_BIT = 5;

    // segment pattern of a decimal digit
    function automatic t_byte glyph_of(input t_digit digit);
        t_byte g;
        unique case (digit)
            4'd0:    g = 8'b1101_0111;
            4'd1:    g = 8'b0001_0100;
            4'd2:    g = 8'b1100_1101;
            4'd3:    g = 8'b0101_1101;
            4'd4:    g = 8'b0001_1110;
            4'd5:    g = 8'b0101_1011;
            4'd6:    g = 8'b1101_1011;
            4'd7:    g = 8'b0001_0101;
            4'd8:    g = 8'b1101_1111;
            default: g = 8'b0101_1111;
        endcase
        return g;
    endfunction

    // one-hot digit select code of a scan position
    function automatic t_byte select_of(input t_pos pos);
        t_byte s;
        unique case (pos)
            3'd0:    s = 8'b1000_0000;
            3'd1:    s = 8'b0100_0000;
            3'd2:    s = 8'b0010_0000;
            3'd3:    s = 8'b0001_0000;
            3'd4:    s = 8'b0000_0010;
            3'd5:    s = 8'b0000_0100;
            3'd6:    s = 8'b0000_1000;
            default: s = 8'b0000_0001;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/sss_if.sv
// valid/ready channel interfaces of the seven-segment scan driver
`timescale 1ns / 1ps

// input channel: two display values per item
interface sss_in_if;
    logic            valid;
    logic            ready;
    sss_pkg::t_value top_value;
    sss_pkg::t_value bottom_value;

    modport source (output valid, output top_value, output bottom_value, input ready);
    modport sink   (input valid, input top_value, input bottom_value, output ready);
endinterface

// result channel: three shift-register bytes and the scan position
interface sss_out_if;
    logic           valid;
    logic           ready;
    sss_pkg::t_byte segment_byte;
    sss_pkg::t_byte select_byte;
    sss_pkg::t_byte aux_byte;
    sss_pkg::t_pos  position;

    modport source (output valid, output segment_byte, output select_byte,
                    output aux_byte, output position, input ready);
    modport sink   (input valid, input segment_byte, input select_byte,
                    input aux_byte, input position, output ready);
endinterface

// configuration write channel
interface sss_cfg_if;
    logic              valid;
    logic              ready;
    sss_pkg::t_cfg_idx index;
    sss_pkg::t_byte    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/seven_segment_scan_driver.sv
// seven-segment scan driver: digit extraction, glyph lookup and scan position
// data path: an accepted item passes through stage a, stage b and the result register
//   (three register stages) before it can leave on the result channel
// throughput: one item per cycle while o_out.ready holds; a full stage moves on whenever the next one empties
// the quotient multiplier and the tens multiplier sit in separate stages
// reset: synchronous, active low; clears stage valid bits, scan position and both
//   configuration registers
`timescale 1ns / 1ps

module seven_segment_scan_driver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sss_in_if.sink      i_in,
    sss_cfg_if.sink     i_cfg,
    sss_out_if.source   o_out
);
    import sss_pkg::*;

    // configuration registers and scan position
    t_byte r_point_mask;
    t_byte r_extra_byte;
    t_pos  r_scan;

    // stage a: clamped value of the current group
    logic     r_a_valid;
    t_clamped r_a_value;
    t_place   r_a_place;
    t_pos     r_a_pos;
    logic     r_a_point;
    t_byte    r_a_aux;

    // stage b: quotient by the place weight
    logic     r_b_valid;
    t_clamped r_b_quot;
    t_pos     r_b_pos;
    logic     r_b_point;
    t_byte    r_b_aux;

    // result register
    logic  r_o_valid;
    t_byte r_o_segment;
    t_byte r_o_select;
    t_byte r_o_aux;
    t_pos  r_o_pos;

    logic     w_o_rdy;
    logic     w_b_rdy;
    logic     w_a_rdy;
    logic     w_in_acc;
    t_value   w_sel_value;
    t_clamped w_clamped;
    t_prod    w_prod_b;
    t_clamped w_quot;
    t_prod    w_prod_c;
    logic [TENS_W-1:0] w_tens;
    t_clamped w_tens10;
    t_clamped w_rem;
    t_digit   w_digit;

    // stall chain from the result side back to the input
    assign w_o_rdy  = !r_o_valid || o_out.ready;
    assign w_b_rdy  = !r_b_valid || w_o_rdy;
    assign w_a_rdy  = !r_a_valid || w_b_rdy;
    assign i_in.ready = w_a_rdy;
    assign w_in_acc = i_in.valid && w_a_rdy;
    assign i_cfg.ready = 1'b1;

    // pick the group of the current position and clamp it
    assign w_sel_value = r_scan[POS_W-1] ? i_in.bottom_value : i_in.top_value;
    assign w_clamped   = (w_sel_value > t_value'(VALUE_CLAMP))
                         ? VALUE_CLAMP : w_sel_value[CLAMP_W-1:0];

    // divide by the place weight through a reciprocal
    always_comb begin
        unique case (r_a_place)
            PLACE_THOUSANDS: begin
                w_prod_b = t_prod'(r_a_value) * RECIP_1000;
                w_quot   = t_clamped'(w_prod_b >> SHIFT_1000);
            end
            PLACE_HUNDREDS: begin
                w_prod_b = t_prod'(r_a_value) * RECIP_100;
                w_quot   = t_clamped'(w_prod_b >> SHIFT_100);
            end
            PLACE_TENS: begin
                w_prod_b = t_prod'(r_a_value) * RECIP_10;
                w_quot   = t_clamped'(w_prod_b >> SHIFT_10);
            end
            default: begin
                w_prod_b = t_prod'(r_a_value);
                w_quot   = r_a_value;
            end
        endcase
    end

    // low decimal digit of the quotient
    assign w_prod_c = t_prod'(r_b_quot) * RECIP_10;
    assign w_tens   = w_prod_c[SHIFT_10 +: TENS_W];
    assign w_tens10 = t_clamped'({w_tens, 3'b000}) + t_clamped'({w_tens, 1'b0});
    assign w_rem    = r_b_quot - w_tens10;
    assign w_digit  = w_rem[DIGIT_W-1:0];

    // configuration writes, scan position and stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_mask <= '0;
            r_extra_byte <= '0;
            r_scan       <= '0;
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == REG_POINT_MASK) begin
                    r_point_mask <= i_cfg.data;
                end else if (i_cfg.index == REG_EXTRA_BYTE) begin
                    r_extra_byte <= i_cfg.data;
                end
            end
            if (w_in_acc) begin
                r_scan <= r_scan + t_pos'(1);
            end
            if (w_a_rdy) begin
                r_a_valid <= i_in.valid;
            end
            if (w_b_rdy) begin
                r_b_valid <= r_a_valid;
            end
            if (w_o_rdy) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_a_rdy) begin
            r_a_value <= w_clamped;
            r_a_place <= r_scan[PLACE_W-1:0];
            r_a_pos   <= r_scan;
            r_a_point <= r_point_mask[r_scan];
            r_a_aux   <= r_extra_byte;
        end
        if (w_b_rdy) begin
            r_b_quot  <= w_quot;
            r_b_pos   <= r_a_pos;
            r_b_point <= r_a_point;
            r_b_aux   <= r_a_aux;
        end
        if (w_o_rdy) begin
            r_o_segment <= glyph_of(w_digit) | (t_byte'(r_b_point) << POINT_BIT);
            r_o_select  <= select_of(r_b_pos);
            r_o_aux     <= r_b_aux;
            r_o_pos     <= r_b_pos;
        end
    end

    // result channel
    assign o_out.valid        = r_o_valid;
    assign o_out.segment_byte = r_o_segment;
    assign o_out.select_byte  = r_o_select;
    assign o_out.aux_byte     = r_o_aux;
    assign o_out.position     = r_o_pos;

    // scan position moves by one on each accepted item and holds otherwise
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_scan == $past(r_scan) + t_pos'(1))
        else $error("scan position did not advance on accepted item");

    a_scan_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> $stable(r_scan))
        else $error("scan position moved without an accepted item");

    // quotient never exceeds the clamp
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> r_b_quot <= VALUE_CLAMP)
        else $error("quotient above clamp");

    // extracted digit is decimal
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> w_rem <= t_clamped'(9))
        else $error("digit extraction out of range");

    // select code is one-hot and matches the position
    a_select_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> $onehot(r_o_select) && r_o_select == select_of(r_o_pos))
        else $error("select code does not match position");

endmodule

>>> tb/seven_segment_scan_driver_tb.sv
// self-checking testbench of the seven-segment scan driver: directed table, then random phases
`timescale 1ns / 1ps

module seven_segment_scan_driver_tb;
    import sss_pkg::*;

    // one result of a scan tick
    typedef struct packed {
        t_byte segment_byte;
        t_byte select_byte;
        t_byte aux_byte;
        t_pos  position;
    } t_scan_result;

    // one row of the directed table; want is used only where typed is set
    typedef struct packed {
        t_value       top_value;
        t_value       bottom_value;
        logic         typed;
        t_scan_result want;
    } t_scan_row;

    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 205;
    localparam int DIRECTED_ROWS   = 24;

    logic i_clk;
    logic i_rst_n;

    sss_in_if  scan_in_if ();
    sss_cfg_if cfg_if ();
    sss_out_if scan_out_if ();

    seven_segment_scan_driver uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (scan_in_if),
        .i_cfg   (cfg_if),
        .o_out   (scan_out_if)
    );

    // segment patterns of digits 0..9 and select codes of positions 0..7
    t_byte digit_glyph [10] = '{8'hD7, 8'h14, 8'hCD, 8'h5D, 8'h1E,
                                8'h5B, 8'hDB, 8'h15, 8'hDF, 8'h5F};
    t_byte position_select [8] = '{8'h80, 8'h40, 8'h20, 8'h10,
                                   8'h02, 8'h04, 8'h08, 8'h01};

    // mirror of the block state and registers
    t_pos  scan_position = '0;
    t_byte point_mask_q  = '0;
    t_byte extra_byte_q  = '0;

    t_scan_result pending_scans [$];
    int unsigned  mismatch_count = 0;

    // sender burst state and receiver stall pattern
    int unsigned  burst_left  = 0;
    logic [31:0]  stall_pattern = '0;
    int unsigned  stall_left  = 0;

    // directed rows: reset config, clamp extremes, then every digit through the predictor
    t_scan_row directed_rows [DIRECTED_ROWS] = '{
        '{16'd0,     16'd0,     1'b1, '{8'hD7, 8'h80, 8'h00, 3'd0}},
        '{16'hFFFF,  16'd0,     1'b1, '{8'h5F, 8'h40, 8'h00, 3'd1}},
        '{16'd10000, 16'hFFFF,  1'b1, '{8'h5F, 8'h20, 8'h00, 3'd2}},
        '{16'd9999,  16'd0,     1'b1, '{8'h5F, 8'h10, 8'h00, 3'd3}},
        '{16'd0,     16'hFFFF,  1'b1, '{8'h5F, 8'h02, 8'h00, 3'd4}},
        '{16'hFFFF,  16'd0,     1'b1, '{8'hD7, 8'h04, 8'h00, 3'd5}},
        '{16'd0,     16'd9999,  1'b1, '{8'h5F, 8'h08, 8'h00, 3'd6}},
        '{16'd0,     16'h8000,  1'b1, '{8'h5F, 8'h01, 8'h00, 3'd7}},
        '{16'd1234,  16'd5678,  1'b0, '0},
        '{16'd1234,  16'd5678,  1'b0, '0},
        '{16'd1234,  16'd5678,  1'b0, '0},
        '{16'd1234,  16'd5678,  1'b0, '0},
        '{16'd1234,  16'd5678,  1'b0, '0},
        '{16'd1234,  16'd5678,  1'b0, '0},
        '{16'd1234,  16'd5678,  1'b0, '0},
        '{16'd1234,  16'd5678,  1'b0, '0},
        '{16'd9087,  16'd6543,  1'b0, '0},
        '{16'd9087,  16'd6543,  1'b0, '0},
        '{16'd9087,  16'd6543,  1'b0, '0},
        '{16'd9087,  16'd6543,  1'b0, '0},
        '{16'd9087,  16'd6543,  1'b0, '0},
        '{16'd9087,  16'd6543,  1'b0, '0},
        '{16'd9087,  16'd6543,  1'b0, '0},
        '{16'd9087,  16'd6543,  1'b0, '0}
    };

    // register settings of the first four random phases, extremes first
    t_byte phase_point_mask [4] = '{8'hFF, 8'h00, 8'h55, 8'hAA};
    t_byte phase_extra_byte [4] = '{8'hFF, 8'h00, 8'hAA, 8'h55};

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // expected result of one tick; advances the mirrored scan position
    function automatic t_scan_result predict_scan(input t_value top, input t_value bottom);
        t_scan_result r;
        int unsigned  shown;
        int unsigned  digit;
        shown = (scan_position < 4) ? 32'(top) : 32'(bottom);
        if (shown > 32'(VALUE_CLAMP))
            shown = 32'(VALUE_CLAMP);
        case (t_place'(scan_position))
            PLACE_THOUSANDS: digit = shown / 1000;
            PLACE_HUNDREDS:  digit = (shown / 100) % 10;
            PLACE_TENS:      digit = (shown / 10) % 10;
            default:         digit = shown % 10;
        endcase
        r.segment_byte = digit_glyph[digit] |
                         (t_byte'(point_mask_q[scan_position]) << POINT_BIT);
        r.select_byte  = position_select[scan_position];
        r.aux_byte     = extra_byte_q;
        r.position     = scan_position;
        scan_position  = scan_position + 1'b1;
        return r;
    endfunction

    // mixes in-range, clamp-edge and over-range values
    function automatic t_value random_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return t_value'(VALUE_CLAMP);
            2:       return t_value'($urandom_range(10000, 65535));
            3:       return '1;
            7:       return t_value'($urandom);
            default: return t_value'($urandom_range(0, 9999));
        endcase
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    // send one item in bursts with random gaps; predict it once accepted
    task automatic send_scan(input t_value top, input t_value bottom, input logic typed,
                             input t_scan_result typed_want);
        int unsigned  gap;
        t_scan_result want;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                scan_in_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        scan_in_if.valid        <= 1'b1;
        scan_in_if.top_value    <= top;
        scan_in_if.bottom_value <= bottom;
        do @(posedge i_clk); while (scan_in_if.ready !== 1'b1);
        want = predict_scan(top, bottom);
        pending_scans.push_back(typed ? typed_want : want);
    endtask

    // register write; out-of-range indexes leave the mirror untouched
    task automatic write_reg(input t_cfg_idx idx, input t_byte data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        if (idx == REG_POINT_MASK)
            point_mask_q = data;
        else if (idx == REG_EXTRA_BYTE)
            extra_byte_q = data;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_scans.size() != 0) @(posedge i_clk);
    endtask

    // receiver ready follows a rotating pattern, reloaded after each full rotation
    always @(negedge i_clk) begin : sink_stall
        if (stall_left == 0) begin
            stall_left    = 32;
            stall_pattern = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
        end
        scan_out_if.ready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
        stall_left--;
    end

    // compare each accepted result with the oldest pending prediction
    always @(posedge i_clk) begin : result_check
        t_scan_result want;
        if (i_rst_n && scan_out_if.valid === 1'b1 && scan_out_if.ready === 1'b1) begin
            if (pending_scans.size() == 0) begin
                $error("result with nothing pending: position %0d", scan_out_if.position);
                mismatch_count++;
            end else begin
                want = pending_scans.pop_front();
                check_field("segment_byte", want.segment_byte, scan_out_if.segment_byte);
                check_field("select_byte", want.select_byte, scan_out_if.select_byte);
                check_field("aux_byte", want.aux_byte, scan_out_if.aux_byte);
                check_field("position", 8'(want.position), 8'(scan_out_if.position));
            end
        end
    end

    // main sequence
    initial begin : stimulus
        t_byte mask_val;
        t_byte extra_val;
        i_rst_n                 = 1'b0;
        scan_in_if.valid        = 1'b0;
        scan_in_if.top_value    = '0;
        scan_in_if.bottom_value = '0;
        cfg_if.valid            = 1'b0;
        cfg_if.index            = '0;
        cfg_if.data             = '0;
        scan_out_if.ready       = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table with reset register values
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_scan(directed_rows[r].top_value, directed_rows[r].bottom_value,
                      directed_rows[r].typed, directed_rows[r].want);

        // random phases, each under its own register setting
        for (int p = 0; p < PHASE_COUNT; p++) begin
            @(negedge i_clk);
            scan_in_if.valid <= 1'b0;
            burst_left = 0;
            wait_drained();
            if (p < 4) begin
                mask_val  = phase_point_mask[p];
                extra_val = phase_extra_byte[p];
            end else begin
                mask_val  = t_byte'($urandom);
                extra_val = t_byte'($urandom);
            end
            write_reg(REG_POINT_MASK, mask_val);
            write_reg(REG_EXTRA_BYTE, extra_val);
            // index past the register file must be ignored
            write_reg(t_cfg_idx'(REG_EXTRA_BYTE + $urandom_range(1, 14)), t_byte'($urandom));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_scan(random_value(), random_value(), 1'b0, '0);
        end

        @(negedge i_clk);
        scan_in_if.valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
rtl/sss_pkg.sv
rtl/sss_if.sv
rtl/seven_segment_scan_driver.sv
tb/seven_segment_scan_driver_tb.sv
